### rtl/glos_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glos_pkg: shared definitions of the grid line-of-sight checker
// Field widths, default grid size, sequencer states and the walk records
// passed between the sequencer and the step unit.
// ----------------------------------------------------------------------------
package glos_pkg;

  // Fixed widths of the coordinate fields
  localparam int COL_W = 7;
  localparam int ROW_W = 6;

  // Default grid size
  localparam int GRID_COLS_DEF = 128;
  localparam int GRID_ROWS_DEF = 64;

  // The error term stays within minus twice the row span and twice the column span
  localparam int ERR_W  = COL_W + 3;
  // The remaining count is at most 1 + dx + dy and may end one below zero
  localparam int LEFT_W = COL_W + 2;

  // Item kinds carried by the mode field
  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_QUERY = 1'b1
  } glos_mode_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_RESP
  } glos_state_t;

  // Position, error term and remaining count of a walk
  typedef struct packed {
    logic        [COL_W-1:0]  x;
    logic        [ROW_W-1:0]  y;
    logic signed [ERR_W-1:0]  err;
    logic signed [LEFT_W-1:0] left;
  } glos_walk_t;

  // Constant increments of a walk, fixed for the whole query
  typedef struct packed {
    logic signed [ERR_W-1:0] ddx;
    logic signed [ERR_W-1:0] ddy;
    logic signed [ERR_W-1:0] ddiag;
    logic                    sx;
    logic                    sy;
  } glos_dir_t;

endpackage
`default_nettype wire

### rtl/glos_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glos_if: stream channels of the grid line-of-sight checker
// Valid/ready channels for the input items and for the result flags.
// ----------------------------------------------------------------------------
interface glos_in_if;
  import glos_pkg::*;

  logic             valid;
  logic             ready;
  logic             mode;
  logic [COL_W-1:0] start_col;
  logic [ROW_W-1:0] start_row;
  logic [COL_W-1:0] end_col;
  logic [ROW_W-1:0] end_row;
  logic             blocked;

  modport source (
    output valid, mode, start_col, start_row, end_col, end_row, blocked,
    input  ready
  );

  modport sink (
    input  valid, mode, start_col, start_row, end_col, end_row, blocked,
    output ready
  );
endinterface

interface glos_out_if;
  logic valid;
  logic ready;
  logic line_clear;

  modport source (
    output valid, line_clear,
    input  ready
  );

  modport sink (
    input  valid, line_clear,
    output ready
  );
endinterface
`default_nettype wire

### rtl/glos_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glos_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module glos_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### rtl/glos_step_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glos_step_unit: one step of the error-term grid traversal
// Moves the walk by one cell in x, in y or diagonally, with a single shared
// adder for the error term.
// ----------------------------------------------------------------------------
module glos_step_unit (
  input  glos_pkg::glos_walk_t cur,
  input  glos_pkg::glos_dir_t  dir,
  output glos_pkg::glos_walk_t nxt
);
  import glos_pkg::*;

  logic        [COL_W-1:0]  x_step;
  logic        [ROW_W-1:0]  y_step;
  logic signed [ERR_W-1:0]  err_delta;
  logic signed [LEFT_W-1:0] left_dec;

  // Neighbouring coordinates in the direction of the end cell
  assign x_step = dir.sx ? (cur.x + COL_W'(1)) : (cur.x - COL_W'(1));
  assign y_step = dir.sy ? (cur.y + ROW_W'(1)) : (cur.y - ROW_W'(1));

  // Select the move and the error increment; a tie moves diagonally and
  // uses up one extra count.
  always_comb begin
    nxt       = cur;
    err_delta = dir.ddiag;
    left_dec  = $signed(LEFT_W'(2));
    if (cur.err > 0) begin
      nxt.x     = x_step;
      err_delta = -dir.ddy;
      left_dec  = $signed(LEFT_W'(1));
    end else if (cur.err < 0) begin
      nxt.y     = y_step;
      err_delta = dir.ddx;
      left_dec  = $signed(LEFT_W'(1));
    end else begin
      nxt.x = x_step;
      nxt.y = y_step;
    end
    nxt.err  = cur.err + err_delta;
    nxt.left = cur.left - left_dec;
  end

endmodule
`default_nettype wire

### rtl/grid_line_of_sight_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_line_of_sight_check: line-of-sight test over a one-bit obstacle grid
// Keeps an obstacle bitmap and walks query lines through it cell by cell.
// ----------------------------------------------------------------------------
// After reset the block clears the obstacle map, one cell a cycle, and
// accepts no item until that is done. A write item (mode 0) sets or clears
// one cell; a cell outside the grid is left alone and no result follows. A
// query item (mode 1) walks from the start cell towards the end cell,
// reading one map cell per cycle from the single read port of the map RAM,
// and yields one line_clear flag. It steps over at most 1 + |dx| + |dy|
// cells; the walk ends early at the first obstacle. Cells outside the grid
// read as free. The input is not ready while a query is in progress, and a
// finished flag waits in an output register until the sink takes it.
// ----------------------------------------------------------------------------
module grid_line_of_sight_check #(
  parameter int GRID_COLS = glos_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = glos_pkg::GRID_ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  glos_in_if.sink           in_ch,
  glos_out_if.source        out_ch
);
  import glos_pkg::*;

  localparam int DEPTH  = GRID_COLS * GRID_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);

  // Map address of a cell, row-major
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] c,
                                                  input logic [ROW_W-1:0] r);
    return ADDR_W'(32'(r) * GRID_COLS + 32'(c));
  endfunction

  // True when the cell lies inside the grid
  function automatic logic in_grid(input logic [COL_W-1:0] c,
                                   input logic [ROW_W-1:0] r);
    return (32'(c) < GRID_COLS) && (32'(r) < GRID_ROWS);
  endfunction

  glos_state_t state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r;
  glos_walk_t  walk_r, walk_init, walk_step;
  glos_dir_t   dir_r, dir_init;
  logic        pend_r, pend_nxt;
  logic        res_r;
  logic        out_valid_r;
  logic        out_line_clear_r;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic              ram_rdata;

  logic in_ready;
  logic query_load;
  logic step_en;
  logic res_load;
  logic out_load;
  logic slot_free;
  logic hit;
  logic walk_done;

  logic             sx;
  logic             sy;
  logic [COL_W-1:0] dx;
  logic [ROW_W-1:0] dy;

  // Obstacle map
  glos_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared step unit
  glos_step_unit u_step (
    .cur (walk_r),
    .dir (dir_r),
    .nxt (walk_step)
  );

  // Spans, directions and starting values of a new query
  assign sx = in_ch.end_col > in_ch.start_col;
  assign sy = in_ch.end_row > in_ch.start_row;
  assign dx = sx ? (in_ch.end_col - in_ch.start_col) : (in_ch.start_col - in_ch.end_col);
  assign dy = sy ? (in_ch.end_row - in_ch.start_row) : (in_ch.start_row - in_ch.end_row);

  always_comb begin
    dir_init.sx    = sx;
    dir_init.sy    = sy;
    dir_init.ddx   = $signed(ERR_W'({dx, 1'b0}));
    dir_init.ddy   = $signed(ERR_W'({dy, 1'b0}));
    dir_init.ddiag = dir_init.ddx - dir_init.ddy;
    walk_init.x    = in_ch.start_col;
    walk_init.y    = in_ch.start_row;
    walk_init.err  = $signed(ERR_W'(dx)) - $signed(ERR_W'(dy));
    walk_init.left = $signed(LEFT_W'(dx) + LEFT_W'(dy) + LEFT_W'(1));
  end

  // A read issued last cycle that returns an obstacle ends the walk at once
  assign hit       = pend_r && ram_rdata;
  assign walk_done = hit || (walk_r.left <= 0);
  assign slot_free = !out_valid_r || out_ch.ready;

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid && (in_ch.mode == MODE_QUERY)) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Output logic of the sequencer
  always_comb begin
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = cell_addr(in_ch.start_col, in_ch.start_row);
    ram_wdata  = in_ch.blocked;
    ram_re     = 1'b0;
    ram_raddr  = cell_addr(walk_r.x, walk_r.y);
    query_load = 1'b0;
    step_en    = 1'b0;
    res_load   = 1'b0;
    out_load   = 1'b0;
    pend_nxt   = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = 1'b0;
      end
      ST_IDLE: begin
        in_ready   = 1'b1;
        ram_we     = in_ch.valid && (in_ch.mode == MODE_WRITE) &&
                     in_grid(in_ch.start_col, in_ch.start_row);
        query_load = in_ch.valid && (in_ch.mode == MODE_QUERY);
      end
      ST_WALK: begin
        if (walk_done) begin
          res_load = 1'b1;
        end else begin
          step_en  = 1'b1;
          pend_nxt = in_grid(walk_r.x, walk_r.y);
          ram_re   = pend_nxt;
        end
      end
      ST_RESP: begin
        out_load = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = in_ready;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      pend_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
    end
  end

  // Walk registers: loaded on a query transfer, advanced once per cell
  always_ff @(posedge clk) begin
    if (query_load) begin
      walk_r <= walk_init;
      dir_r  <= dir_init;
    end else if (step_en) begin
      walk_r <= walk_step;
    end
    if (res_load) begin
      res_r <= !hit;
    end
  end

  // Output register: holds the flag until the sink takes the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_line_clear_r <= res_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.line_clear = out_line_clear_r;

  // A new flag only appears when the sequencer hands over a finished query.
  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESP))
    else $error("result flag raised outside the hand-over state");

  // A pending map read always stems from a walk step in the cycle before.
  a_pend_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> $past(state_r == ST_WALK))
    else $error("map read pending without a walk step");

  // The map is never written while a line is being walked.
  a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> !ram_we)
    else $error("map written during a walk");

  // The remaining count never falls more than one below zero.
  a_left_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (walk_r.left >= -1))
    else $error("walk count ran below its floor");

endmodule
`default_nettype wire

### tb/grid_line_of_sight_check_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_line_of_sight_check_tb: self-checking bench of the line-of-sight block
// Drives write and query items through the input channel and checks every
// line_clear flag against a bench-side obstacle map and grid walk, or against
// a flag typed into the directed table. A short table of directed items comes
// first, then constrained-random traffic with bursts of idling on both channels.
// ----------------------------------------------------------------------------
module grid_line_of_sight_check_tb;
  import glos_pkg::*;

  localparam int GRID_COLS    = GRID_COLS_DEF;
  localparam int GRID_ROWS    = GRID_ROWS_DEF;
  localparam int RANDOM_ITEMS = 1250;
  localparam int TAIL_ITEMS   = 150;
  localparam int QUIET_LIMIT  = 50000;
  localparam int DRAIN_CYCLES = 250;
  localparam int REPORT_MAX   = 10;
  localparam int N_DIRECTED   = 24;
  localparam int HOT_COL      = 32;
  localparam int HOT_ROW      = 16;

  // How the flag of a directed query is known: from the bench walk or typed in.
  typedef enum logic [1:0] {
    BY_MODEL,
    WANT_CLEAR,
    WANT_BLOCKED
  } los_check_t;

  typedef struct packed {
    glos_mode_t       mode;
    logic [COL_W-1:0] start_col;
    logic [ROW_W-1:0] start_row;
    logic [COL_W-1:0] end_col;
    logic [ROW_W-1:0] end_row;
    logic             blocked;
    los_check_t       check;
  } los_item_t;

  logic clk = 1'b0;
  logic rst_n;

  glos_in_if  in_ch ();
  glos_out_if out_ch ();

  grid_line_of_sight_check #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Bench copy of the obstacle map; it starts all free, as after reset.
  bit          obstacle_model [GRID_ROWS][GRID_COLS];
  logic        clear_flags_due [$];
  int unsigned mismatch_count = 0;
  int unsigned result_count   = 0;
  int unsigned quiet_cycles   = 0;
  bit          steady_tail    = 1'b0;

  // Directed items: corners, single-cell lines, axis lines, a diagonal that
  // slips between two obstacles, ignored fields and clearing of cells.
  los_item_t directed_rows [N_DIRECTED] = '{
    '{MODE_QUERY, 7'd0,   6'd0,  7'd127, 6'd63, 1'b0, WANT_CLEAR},
    '{MODE_QUERY, 7'd127, 6'd63, 7'd0,   6'd0,  1'b1, WANT_CLEAR},
    '{MODE_QUERY, 7'd127, 6'd0,  7'd0,   6'd63, 1'b0, WANT_CLEAR},
    '{MODE_WRITE, 7'd0,   6'd0,  7'd127, 6'd63, 1'b1, BY_MODEL},
    '{MODE_QUERY, 7'd0,   6'd0,  7'd0,   6'd0,  1'b0, WANT_BLOCKED},
    '{MODE_QUERY, 7'd127, 6'd63, 7'd0,   6'd0,  1'b0, BY_MODEL},
    '{MODE_WRITE, 7'd127, 6'd63, 7'd0,   6'd0,  1'b1, BY_MODEL},
    '{MODE_QUERY, 7'd127, 6'd63, 7'd127, 6'd63, 1'b0, WANT_BLOCKED},
    '{MODE_WRITE, 7'd0,   6'd0,  7'd0,   6'd0,  1'b0, BY_MODEL},
    '{MODE_QUERY, 7'd0,   6'd0,  7'd0,   6'd0,  1'b1, WANT_CLEAR},
    '{MODE_QUERY, 7'd0,   6'd0,  7'd127, 6'd0,  1'b0, WANT_CLEAR},
    '{MODE_WRITE, 7'd64,  6'd32, 7'd127, 6'd63, 1'b1, BY_MODEL},
    '{MODE_QUERY, 7'd64,  6'd0,  7'd64,  6'd63, 1'b0, WANT_BLOCKED},
    '{MODE_QUERY, 7'd127, 6'd32, 7'd0,   6'd32, 1'b0, WANT_BLOCKED},
    '{MODE_QUERY, 7'd0,   6'd0,  7'd127, 6'd63, 1'b0, BY_MODEL},
    '{MODE_WRITE, 7'd11,  6'd10, 7'd0,   6'd0,  1'b1, BY_MODEL},
    '{MODE_WRITE, 7'd10,  6'd11, 7'd0,   6'd0,  1'b1, BY_MODEL},
    '{MODE_QUERY, 7'd10,  6'd10, 7'd12,  6'd12, 1'b0, BY_MODEL},
    '{MODE_QUERY, 7'd12,  6'd12, 7'd10,  6'd10, 1'b1, BY_MODEL},
    '{MODE_QUERY, 7'd10,  6'd10, 7'd13,  6'd12, 1'b0, BY_MODEL},
    '{MODE_QUERY, 7'd70,  6'd40, 7'd58,  6'd35, 1'b0, BY_MODEL},
    '{MODE_WRITE, 7'd64,  6'd32, 7'd0,   6'd0,  1'b0, BY_MODEL},
    '{MODE_WRITE, 7'd127, 6'd63, 7'd0,   6'd0,  1'b0, BY_MODEL},
    '{MODE_QUERY, 7'd127, 6'd63, 7'd0,   6'd0,  1'b0, BY_MODEL}
  };

  // Clock: period of 10 time units.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Walks the error-term traversal over the bench map. A tie on the error
  // term moves diagonally and uses up one extra count; cells outside the
  // grid read as free.
  function automatic logic trace_line_clear(int c0, int r0, int c1, int r1);
    int span_c, span_r, step_c, step_r, col, row, remaining, err;
    span_c    = (c1 > c0) ? c1 - c0 : c0 - c1;
    span_r    = (r1 > r0) ? r1 - r0 : r0 - r1;
    step_c    = (c1 > c0) ? 1 : -1;
    step_r    = (r1 > r0) ? 1 : -1;
    col       = c0;
    row       = r0;
    remaining = 1 + span_c + span_r;
    err       = span_c - span_r;
    while (remaining > 0) begin
      if (col >= 0 && row >= 0 && col < GRID_COLS && row < GRID_ROWS &&
          obstacle_model[row][col])
        return 1'b0;
      if (err > 0) begin
        col += step_c;
        err -= 2 * span_r;
      end else if (err < 0) begin
        row += step_r;
        err += 2 * span_c;
      end else begin
        col += step_c;
        row += step_r;
        err += 2 * span_c - 2 * span_r;
        remaining--;
      end
      remaining--;
    end
    return 1'b1;
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("%s", msg);
  endtask

  // Appends one expected flag behind the ones still outstanding.
  task automatic book_flag(input logic flag);
    clear_flags_due = {clear_flags_due, flag};
  endtask

  // The sender idles now and then for a random gap, never in the tail.
  function automatic int unsigned pick_send_gap();
    if (!steady_tail && $urandom_range(0, 3) == 0)
      return $urandom_range(1, 10);
    return 0;
  endfunction

  // Presents one item from a falling edge, waits for its transfer, books the
  // expected flag or the map update, and returns at the next falling edge.
  task automatic send_item(input los_item_t it, input int unsigned gap);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= it.mode;
    in_ch.start_col <= it.start_col;
    in_ch.start_row <= it.start_row;
    in_ch.end_col   <= it.end_col;
    in_ch.end_row   <= it.end_row;
    in_ch.blocked   <= it.blocked;
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
    if (it.mode == MODE_WRITE) begin
      if (int'(it.start_col) < GRID_COLS && int'(it.start_row) < GRID_ROWS)
        obstacle_model[it.start_row][it.start_col] = it.blocked;
    end else begin
      case (it.check)
        WANT_CLEAR:   book_flag(1'b1);
        WANT_BLOCKED: book_flag(1'b0);
        default: begin
          book_flag(trace_line_clear(it.start_col, it.start_row,
                                     it.end_col, it.end_row));
        end
      endcase
    end
    @(negedge clk);
  endtask

  // Result side: ready drops in random bursts, and stays high in the tail.
  initial begin : result_sink
    int unsigned hold;
    hold         = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (steady_tail) begin
        out_ch.ready <= 1'b1;
      end else if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else if ($urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        hold = $urandom_range(1, 10) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Checks each result transfer against the oldest expected flag, and ends
  // the run if no transfer happens on either channel for too long.
  always @(posedge clk) begin : result_check
    logic want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      result_count++;
      if (clear_flags_due.size() == 0) begin
        note_failure($sformatf("result %0d: line_clear=%b with no query outstanding",
                               result_count, out_ch.line_clear));
      end else begin
        want = clear_flags_due.pop_front();
        if (out_ch.line_clear !== want)
          note_failure($sformatf("result %0d: line_clear expected %b, got %b",
                                 result_count, want, out_ch.line_clear));
      end
    end
    if (rst_n && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Stimulus: reset, the directed table, then random traffic.
  initial begin : stimulus
    los_item_t it;
    int        shape, c, r, d;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_WRITE;
    in_ch.start_col = '0;
    in_ch.start_row = '0;
    in_ch.end_col   = '0;
    in_ch.end_row   = '0;
    in_ch.blocked   = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k])
      send_item(directed_rows[k], pick_send_gap());

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady_tail = (n >= RANDOM_ITEMS - TAIL_ITEMS);

      // Once, halfway, hold the input back until every flag has come out.
      if (n == RANDOM_ITEMS / 2) begin
        in_ch.valid <= 1'b0;
        while (clear_flags_due.size() != 0)
          @(posedge clk);
        @(negedge clk);
      end

      it           = '0;
      it.check     = BY_MODEL;
      it.blocked   = 1'($urandom_range(0, 1));
      it.start_col = COL_W'($urandom_range(0, GRID_COLS - 1));
      it.start_row = ROW_W'($urandom_range(0, GRID_ROWS - 1));
      it.end_col   = COL_W'($urandom_range(0, GRID_COLS - 1));
      it.end_row   = ROW_W'($urandom_range(0, GRID_ROWS - 1));

      if ($urandom_range(0, 99) < 40) begin
        // Writes land mostly in a hot patch, so that queries there meet obstacles.
        it.mode = MODE_WRITE;
        if ($urandom_range(0, 2) != 0) begin
          it.start_col = COL_W'(HOT_COL + $urandom_range(0, 31));
          it.start_row = ROW_W'(HOT_ROW + $urandom_range(0, 15));
        end
        it.blocked = ($urandom_range(0, 9) < 7);
      end else begin
        it.mode = MODE_QUERY;
        shape   = $urandom_range(0, 9);
        if (shape <= 5) begin
          // Short line around the hot patch.
          c = HOT_COL - 8 + $urandom_range(0, 47);
          r = HOT_ROW - 8 + $urandom_range(0, 31);
          it.start_col = COL_W'(c);
          it.start_row = ROW_W'(r);
          c += int'($urandom_range(0, 24)) - 12;
          r += int'($urandom_range(0, 24)) - 12;
          c = (c < 0) ? 0 : (c > GRID_COLS - 1) ? GRID_COLS - 1 : c;
          r = (r < 0) ? 0 : (r > GRID_ROWS - 1) ? GRID_ROWS - 1 : r;
          it.end_col = COL_W'(c);
          it.end_row = ROW_W'(r);
        end else if (shape == 8) begin
          // Straight along a row or a column.
          if ($urandom_range(0, 1) != 0)
            it.end_row = it.start_row;
          else
            it.end_col = it.start_col;
        end else if (shape == 9) begin
          // Exact diagonal: every step is a tie on the error term.
          c = HOT_COL + $urandom_range(0, 31);
          r = 20 + $urandom_range(0, 23);
          d = $urandom_range(0, 20);
          it.start_col = COL_W'(c);
          it.start_row = ROW_W'(r);
          it.end_col   = COL_W'(($urandom_range(0, 1) != 0) ? c + d : c - d);
          it.end_row   = ROW_W'(($urandom_range(0, 1) != 0) ? r + d : r - d);
        end
      end
      send_item(it, pick_send_gap());
    end

    // Drain: wait for the last flags, then idle before the verdict.
    in_ch.valid <= 1'b0;
    while (clear_flags_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire

### files.f
rtl/glos_pkg.sv
rtl/glos_if.sv
rtl/glos_ram.sv
rtl/glos_step_unit.sv
rtl/grid_line_of_sight_check.sv
tb/grid_line_of_sight_check_tb.sv
